// ===== rtl/oaht_pkg.sv =====
// Package with types, constants and the key hash function of the hash table core.
package oaht_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_CHARS   = 3;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 11;
  localparam int KEY_W       = 24;
  localparam int VAL_W       = 32;
  localparam int HASH_W      = 28;
  localparam int SQ_W        = 29;
  localparam int ROOT_W      = 15;
  localparam int SQ_STEPS    = 15;
  localparam int MOD_STEPS   = HASH_W;
  localparam int ENTRY_W     = 2 + KEY_W + VAL_W;
  localparam logic [CNT_W-1:0] MODULUS_RESET = CNT_W'(1021);
  localparam logic [CNT_W-1:0] DEPTH_CNT     = CNT_W'(TABLE_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_PROBE   = SLOT_W'(TABLE_DEPTH - 1);
  localparam logic [SLOT_W-1:0] OVER_LIMIT   = SLOT_W'(10);
  localparam logic [HASH_W-1:0] DJB_SEED     = HASH_W'(5381);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_TAKEN = 2'd1,
    SLOT_TOMB  = 2'd2,
    SLOT_BAD   = 2'd3
  } slot_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HMOD, S_PREP, S_SQRT, S_MUL, S_PMOD, S_READ, S_CHECK, S_DONE
  } fsm_t;

  // djb2 over the key characters, first character in the top byte.
  function automatic logic [HASH_W-1:0] djb2(input logic [KEY_W-1:0] code);
    logic [HASH_W-1:0] h;
    h = DJB_SEED;
    for (int i = 0; i < KEY_CHARS; i++) begin
      h = (h << 5) + h + HASH_W'(code[(KEY_CHARS-1-i)*8 +: 8]);
    end
    return h;
  endfunction

endpackage

// ===== rtl/open_addressing_hash_table_core.sv =====
// Open-addressing hash table core: djb2 key hash, square-root stepped probing.
// Steps: a bit-serial modulo of the hash, then per probe a setup, a square root,
// a multiply, a modulo by the configured modulus, a read and a check, then the output register.
// One request at a time: a request is finished before the next one is accepted.
// After reset a clearing pass marks all 1024 slots empty, during which no request
// is accepted; configuration writes are taken as ever.
module open_addressing_hash_table_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [oaht_pkg::CNT_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     kind,
  input  logic [oaht_pkg::KEY_W-1:0]     key_code,
  input  logic [oaht_pkg::VAL_W-1:0]     entry_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     status,
  output logic [oaht_pkg::VAL_W-1:0]     found_value,
  output logic [oaht_pkg::CNT_W-1:0]     probe_count,
  output logic [oaht_pkg::CNT_W-1:0]     entry_count,
  output logic [oaht_pkg::CNT_W-1:0]     max_probes,
  output logic [oaht_pkg::CNT_W-1:0]     over_ten_count,
  output logic [oaht_pkg::VAL_W-1:0]     total_probes
);

  oaht_pkg::fsm_t state, state_next;

  logic [oaht_pkg::CNT_W-1:0]   table_modulus;
  logic [oaht_pkg::CNT_W-1:0]   modulus;

  // Request registers.
  logic [1:0]                   op;
  logic [oaht_pkg::KEY_W-1:0]   key;
  logic [oaht_pkg::VAL_W-1:0]   val;
  logic [oaht_pkg::HASH_W-1:0]  hash;
  logic [oaht_pkg::SLOT_W-1:0]  hash_mod;
  logic [oaht_pkg::SLOT_W-1:0]  attempt;

  // Square root unit.
  logic [oaht_pkg::SQ_W-1:0]    sq_v, sq_res, sq_bit;
  logic [oaht_pkg::SQ_W:0]      sq_sum;
  logic                         sq_take;
  logic [3:0]                   sq_cnt;

  // Shared bit-serial modulo unit.
  logic [oaht_pkg::HASH_W-1:0]  mod_num;
  logic [oaht_pkg::SLOT_W-1:0]  mod_rem;
  logic [oaht_pkg::CNT_W-1:0]   mod_sh;
  logic [oaht_pkg::CNT_W-1:0]   mod_nxt;
  logic [4:0]                   mod_cnt;

  // Result and statistics.
  logic [1:0]                   res_status;
  logic [oaht_pkg::VAL_W-1:0]   res_found;
  logic [oaht_pkg::CNT_W-1:0]   ent_cnt, max_cnt, over_cnt;
  logic [oaht_pkg::VAL_W-1:0]   tot_cnt;
  logic [oaht_pkg::VAL_W:0]     tot_sum;

  logic [oaht_pkg::SLOT_W-1:0]  clr_idx;

  // Slot memory: {state, key, value}.
  logic                          mem_we;
  logic [oaht_pkg::SLOT_W-1:0]   mem_waddr;
  logic [oaht_pkg::ENTRY_W-1:0]  mem_wdata, mem_rdata;
  logic [1:0]                    rd_state;
  logic [oaht_pkg::KEY_W-1:0]    rd_key;
  logic [oaht_pkg::VAL_W-1:0]    rd_val;
  logic                          key_hit;

  logic accept, out_load, probe_end, last_probe;

  oaht_ram #(.WIDTH(oaht_pkg::ENTRY_W), .DEPTH(oaht_pkg::TABLE_DEPTH)) u_slots (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mod_rem),
    .rdata (mem_rdata)
  );

  // A modulus of zero acts as one, and one above the depth as the depth.
  always_comb begin
    if (table_modulus == '0) begin
      modulus = oaht_pkg::CNT_W'(1);
    end else if (table_modulus > oaht_pkg::DEPTH_CNT) begin
      modulus = oaht_pkg::DEPTH_CNT;
    end else begin
      modulus = table_modulus;
    end
  end

  assign rd_state = mem_rdata[oaht_pkg::ENTRY_W-1 -: 2];
  assign rd_key   = mem_rdata[oaht_pkg::VAL_W +: oaht_pkg::KEY_W];
  assign rd_val   = mem_rdata[oaht_pkg::VAL_W-1:0];
  assign key_hit  = (rd_state == oaht_pkg::SLOT_TAKEN) && (rd_key == key);

  assign in_stall = (state != oaht_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state == oaht_pkg::S_DONE) && (!out_valid || !out_stall);
  assign last_probe = (attempt == oaht_pkg::LAST_PROBE);

  assign sq_sum  = {1'b0, sq_res} + {1'b0, sq_bit};
  assign sq_take = {1'b0, sq_v} >= sq_sum;

  assign mod_sh  = {mod_rem, mod_num[oaht_pkg::HASH_W-1]};
  assign mod_nxt = (mod_sh >= modulus) ? (mod_sh - modulus) : mod_sh;

  assign tot_sum = {1'b0, tot_cnt} + (oaht_pkg::VAL_W + 1)'(attempt);

  // The probe ends when the slot decides the outcome.
  always_comb begin
    if (op == oaht_pkg::OP_INSERT) begin
      probe_end = (rd_state != oaht_pkg::SLOT_TAKEN) || key_hit;
    end else begin
      probe_end = (rd_state == oaht_pkg::SLOT_EMPTY) || key_hit;
    end
  end

  // Next state and memory write port.
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = mod_rem;
    mem_wdata  = {oaht_pkg::SLOT_TAKEN, key, val};
    case (state)
      oaht_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
        if (clr_idx == oaht_pkg::LAST_PROBE) state_next = oaht_pkg::S_IDLE;
      end
      oaht_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (kind == oaht_pkg::OP_NONE) ? oaht_pkg::S_DONE : oaht_pkg::S_HMOD;
        end
      end
      oaht_pkg::S_HMOD: if (mod_cnt == '0) state_next = oaht_pkg::S_PREP;
      oaht_pkg::S_PREP: state_next = oaht_pkg::S_SQRT;
      oaht_pkg::S_SQRT: if (sq_cnt == '0) state_next = oaht_pkg::S_MUL;
      oaht_pkg::S_MUL:  state_next = oaht_pkg::S_PMOD;
      oaht_pkg::S_PMOD: if (mod_cnt == '0) state_next = oaht_pkg::S_READ;
      oaht_pkg::S_READ: state_next = oaht_pkg::S_CHECK;
      oaht_pkg::S_CHECK: begin
        if (probe_end || last_probe) begin
          state_next = oaht_pkg::S_DONE;
        end else begin
          state_next = oaht_pkg::S_PREP;
        end
        if (op == oaht_pkg::OP_INSERT && rd_state != oaht_pkg::SLOT_TAKEN) begin
          mem_we = 1'b1;
        end
        if (op == oaht_pkg::OP_DELETE && key_hit) begin
          mem_we    = 1'b1;
          mem_wdata = {oaht_pkg::SLOT_TOMB, key, oaht_pkg::VAL_W'(0)};
        end
      end
      oaht_pkg::S_DONE: if (out_load) state_next = oaht_pkg::S_IDLE;
      default: state_next = oaht_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oaht_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_modulus <= oaht_pkg::MODULUS_RESET;
    end else if (cfg_wen) begin
      table_modulus <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == oaht_pkg::S_CLEAR) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // Datapath of the probe sequence.
  always_ff @(posedge clk) begin
    case (state)
      oaht_pkg::S_IDLE: begin
        op         <= kind;
        key        <= key_code;
        val        <= entry_value;
        hash       <= oaht_pkg::djb2(key_code);
        mod_num    <= oaht_pkg::djb2(key_code);
        mod_rem    <= '0;
        mod_cnt    <= 5'(oaht_pkg::MOD_STEPS - 1);
        attempt    <= '0;
        res_status <= oaht_pkg::ST_DONE;
        res_found  <= '0;
      end
      oaht_pkg::S_HMOD, oaht_pkg::S_PMOD: begin
        mod_rem <= mod_nxt[oaht_pkg::SLOT_W-1:0];
        mod_num <= mod_num << 1;
        mod_cnt <= mod_cnt - 1'b1;
        if (state == oaht_pkg::S_HMOD && mod_cnt == '0) begin
          hash_mod <= mod_nxt[oaht_pkg::SLOT_W-1:0];
        end
      end
      oaht_pkg::S_PREP: begin
        sq_v   <= oaht_pkg::SQ_W'(hash) + oaht_pkg::SQ_W'(attempt * attempt);
        sq_res <= '0;
        sq_bit <= oaht_pkg::SQ_W'(1) << (2 * (oaht_pkg::SQ_STEPS - 1));
        sq_cnt <= 4'(oaht_pkg::SQ_STEPS - 1);
      end
      oaht_pkg::S_SQRT: begin
        if (sq_take) begin
          sq_v   <= sq_v - sq_sum[oaht_pkg::SQ_W-1:0];
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        sq_cnt <= sq_cnt - 1'b1;
      end
      oaht_pkg::S_MUL: begin
        // The sum stays below twice the product bound, well inside the divider width.
        mod_num <= oaht_pkg::HASH_W'(attempt * sq_res[oaht_pkg::ROOT_W-1:0])
                 + oaht_pkg::HASH_W'(hash_mod);
        mod_rem <= '0;
        mod_cnt <= 5'(oaht_pkg::MOD_STEPS - 1);
      end
      oaht_pkg::S_CHECK: begin
        if (probe_end) begin
          if (key_hit && op == oaht_pkg::OP_INSERT) begin
            res_status <= oaht_pkg::ST_DUPLICATE;
          end else if (key_hit) begin
            res_status <= oaht_pkg::ST_DONE;
            if (op == oaht_pkg::OP_SEARCH) res_found <= rd_val;
          end else if (op == oaht_pkg::OP_INSERT) begin
            res_status <= oaht_pkg::ST_DONE;
          end else begin
            res_status <= oaht_pkg::ST_NOT_FOUND;
          end
        end else if (last_probe) begin
          res_status <= (op == oaht_pkg::OP_INSERT) ? oaht_pkg::ST_FULL
                                                    : oaht_pkg::ST_NOT_FOUND;
        end else begin
          attempt <= attempt + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Table statistics.
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_cnt  <= '0;
      max_cnt  <= '0;
      over_cnt <= '0;
      tot_cnt  <= '0;
    end else if (state == oaht_pkg::S_CHECK) begin
      if (op == oaht_pkg::OP_INSERT && rd_state != oaht_pkg::SLOT_TAKEN) begin
        if (ent_cnt != '1) ent_cnt <= ent_cnt + 1'b1;
        if (attempt > oaht_pkg::OVER_LIMIT && over_cnt != '1) over_cnt <= over_cnt + 1'b1;
        if (oaht_pkg::CNT_W'(attempt) > max_cnt) max_cnt <= oaht_pkg::CNT_W'(attempt);
        tot_cnt <= tot_sum[oaht_pkg::VAL_W] ? '1 : tot_sum[oaht_pkg::VAL_W-1:0];
      end
      if (op == oaht_pkg::OP_DELETE && key_hit && ent_cnt != '0) begin
        ent_cnt <= ent_cnt - 1'b1;
      end
    end
  end

  // Output register: holds a finished result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status         <= res_status;
      found_value    <= res_found;
      probe_count    <= oaht_pkg::CNT_W'(attempt);
      entry_count    <= ent_cnt;
      max_probes     <= max_cnt;
      over_ten_count <= over_cnt;
      total_probes   <= tot_cnt;
    end
  end

endmodule

// ===== rtl/oaht_ram.sv =====
// Generic simple dual-port RAM with a registered read.
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/oaht_checker.sv =====
// Port-level checker for the hash table core, with its bind statement.
module oaht_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [1:0]                 status,
  input logic [oaht_pkg::VAL_W-1:0] found_value,
  input logic [oaht_pkg::CNT_W-1:0] probe_count
);

  // The clearing pass keeps requests out right after reset.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("request accepted during the clearing pass");

  // Only one request is worked at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request accepted back to back");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(found_value)))
    else $error("stalled result changed");

  // A payload is reported only on a successful operation.
  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != oaht_pkg::ST_DONE) |-> (found_value == '0))
    else $error("payload reported on a failed request");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (probe_count < oaht_pkg::DEPTH_CNT))
    else $error("probe count beyond the probe limit");

endmodule

bind open_addressing_hash_table_core oaht_checker u_oaht_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .found_value (found_value),
  .probe_count (probe_count)
);

// ===== tb/open_addressing_hash_table_core_tb.sv =====
// Self-checking testbench for the open-addressing hash table core.
module open_addressing_hash_table_core_tb;
  import oaht_pkg::*;

  // Longest run without any handshake: a walk of every probe of a full table,
  // plus the clearing pass and a long receiver hold.
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 100;
  localparam int RANDOM_PER_PHASE = 270;
  localparam int MAX_REPORTS    = 10;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  // One result of the table, as the core should report it.
  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] found;
    logic [CNT_W-1:0] probes;
    logic [CNT_W-1:0] entries;
    logic [CNT_W-1:0] max_probe;
    logic [CNT_W-1:0] over_ten;
    logic [VAL_W-1:0] probe_sum;
  } table_result_t;

  logic             clk;
  logic             rst;
  logic             cfg_wen;
  logic [CNT_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       kind;
  logic [KEY_W-1:0] key_code;
  logic [VAL_W-1:0] entry_value;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       status;
  logic [VAL_W-1:0] found_value;
  logic [CNT_W-1:0] probe_count;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] max_probes;
  logic [CNT_W-1:0] over_ten_count;
  logic [VAL_W-1:0] total_probes;

  open_addressing_hash_table_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .key_code       (key_code),
    .entry_value    (entry_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .found_value    (found_value),
    .probe_count    (probe_count),
    .entry_count    (entry_count),
    .max_probes     (max_probes),
    .over_ten_count (over_ten_count),
    .total_probes   (total_probes)
  );

  // Shadow copy of the table and its counters, kept in step with every
  // accepted request and configuration write.
  slot_t            shadow_state [TABLE_DEPTH];
  logic [KEY_W-1:0] shadow_key   [TABLE_DEPTH];
  logic [VAL_W-1:0] shadow_value [TABLE_DEPTH];
  logic [CNT_W-1:0] shadow_modulus;
  logic [CNT_W-1:0] shadow_entries;
  logic [CNT_W-1:0] shadow_max_probe;
  logic [CNT_W-1:0] shadow_over_ten;
  logic [VAL_W-1:0] shadow_probe_sum;

  table_result_t    pending_results[$];
  logic [KEY_W-1:0] stored_keys[$];
  int               mismatches;
  int               send_idle_pct;
  int               recv_stall_pct;
  bit               hold_ask;
  int               hold_left;
  int               quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned key_hash(input logic [KEY_W-1:0] code);
    longint unsigned h;
    h = 64'd5381;
    for (int i = KEY_CHARS - 1; i >= 0; i--) begin
      h = h * 33 + longint'(code[i*8 +: 8]);
    end
    return h;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= v) begin
        root = root | (64'd1 << b);
      end
    end
    return root;
  endfunction

  function automatic int probe_slot(input longint unsigned h, input longint unsigned a,
                                    input longint unsigned m);
    longint unsigned step;
    step = floor_sqrt(h + a * a);
    return int'(((h % m) + ((a * step) % m)) % m);
  endfunction

  function automatic logic [CNT_W-1:0] clamp_count(input longint unsigned v);
    return (v > longint'(CNT_SAT)) ? CNT_SAT : CNT_W'(v);
  endfunction

  // Applies one request to the shadow table and returns what the core must say.
  task automatic apply_request(input op_t op, input logic [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] val, output table_result_t r);
    longint unsigned m;
    longint unsigned h;
    longint unsigned a;
    longint unsigned sum;
    int  s;
    bit  hit;
    m = (shadow_modulus == 0) ? 1 : longint'(shadow_modulus);
    if (m > TABLE_DEPTH) m = TABLE_DEPTH;
    h = key_hash(key);
    hit = 1'b0;
    a = 0;
    r = '0;
    r.status = ST_DONE;
    if (op == OP_INSERT) begin
      r.status = ST_FULL;
      for (a = 0; a < TABLE_DEPTH; a++) begin
        s = probe_slot(h, a, m);
        if (shadow_state[s] == SLOT_TAKEN) begin
          if (shadow_key[s] == key) begin
            r.status = ST_DUPLICATE;
            hit = 1'b1;
            break;
          end
        end else begin
          // Empty slots and tombstones are both free for an insert.
          shadow_state[s] = SLOT_TAKEN;
          shadow_key[s] = key;
          shadow_value[s] = val;
          shadow_entries = clamp_count(longint'(shadow_entries) + 1);
          if (a > 10) shadow_over_ten = clamp_count(longint'(shadow_over_ten) + 1);
          if (clamp_count(a) > shadow_max_probe) shadow_max_probe = clamp_count(a);
          sum = longint'(shadow_probe_sum) + a;
          shadow_probe_sum = (sum > 64'hFFFF_FFFF) ? '1 : VAL_W'(sum);
          r.status = ST_DONE;
          hit = 1'b1;
          break;
        end
      end
    end else if (op == OP_SEARCH || op == OP_DELETE) begin
      r.status = ST_NOT_FOUND;
      for (a = 0; a < TABLE_DEPTH; a++) begin
        s = probe_slot(h, a, m);
        if (shadow_state[s] == SLOT_EMPTY) begin
          hit = 1'b1;
          break;
        end
        if (shadow_state[s] == SLOT_TAKEN && shadow_key[s] == key) begin
          if (op == OP_SEARCH) begin
            r.found = shadow_value[s];
          end else begin
            shadow_state[s] = SLOT_TOMB;
            shadow_value[s] = '0;
            if (shadow_entries > 0) shadow_entries = shadow_entries - 1'b1;
          end
          r.status = ST_DONE;
          hit = 1'b1;
          break;
        end
      end
    end
    // A walk that used every attempt reports the last attempt number.
    if (op != OP_NONE && !hit) a = TABLE_DEPTH - 1;
    r.probes    = (op == OP_NONE) ? '0 : clamp_count(a);
    r.entries   = shadow_entries;
    r.max_probe = shadow_max_probe;
    r.over_ten  = shadow_over_ten;
    r.probe_sum = shadow_probe_sum;
  endtask

  // Tracks every handshake at the clock edge where it takes effect.
  always @(posedge clk) begin
    table_result_t r;
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) shadow_state[i] = SLOT_EMPTY;
      shadow_modulus   = MODULUS_RESET;
      shadow_entries   = '0;
      shadow_max_probe = '0;
      shadow_over_ten  = '0;
      shadow_probe_sum = '0;
    end else begin
      if (cfg_wen) shadow_modulus = cfg_wdata;
      if (in_valid && !in_stall) begin
        apply_request(op_t'(kind), key_code, entry_value, r);
        pending_results.insert(pending_results.size(), r);
      end
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    table_result_t want;
    table_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got = '{status_t'(status), found_value, probe_count, entry_count, max_probes,
              over_ten_count, total_probes};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  // The receiver stalls at random, or for a long counted stretch on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (hold_ask) begin
      hold_ask = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles in which neither channel moves a request or result.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request and returns at the edge where it is accepted. The valid
  // line stays high so that a following request can go out back to back.
  task automatic send_request(input op_t op, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= op;
    key_code    <= key;
    entry_value <= val;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Called once no results are pending; the first call falls in the clearing pass.
  task automatic write_modulus(input logic [CNT_W-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  task automatic insert_new(input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] val);
    send_request(OP_INSERT, key, val);
    stored_keys.insert(stored_keys.size(), key);
  endtask

  // Field extremes, every operation, duplicates, deletes and the no-op kind.
  task automatic test_basic_ops;
    write_modulus(MODULUS_RESET);
    insert_new(24'h000000, 32'h0000_0000);
    insert_new(24'hFFFFFF, 32'hFFFF_FFFF);
    insert_new(24'h414243, 32'h1234_5678);
    send_request(OP_INSERT, 24'hFFFFFF, 32'h5555_5555);
    send_request(OP_SEARCH, 24'h000000, 32'hFFFF_FFFF);
    send_request(OP_SEARCH, 24'hFFFFFF, 32'h0);
    send_request(OP_SEARCH, 24'h414243, 32'h0);
    send_request(OP_SEARCH, 24'h7A7A7A, 32'h0);
    send_request(OP_DELETE, 24'h414243, 32'h0);
    send_request(OP_DELETE, 24'h414243, 32'h0);
    send_request(OP_SEARCH, 24'h414243, 32'h0);
    send_request(OP_NONE, 24'hFFFFFF, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 24'h414243, 32'hAAAA_AAAA);
    drain();
  endtask

  // A modulus of zero acts as one, so every probe hits slot zero and the
  // probe limit is reached for full and not-found outcomes alike.
  task automatic test_modulus_extremes;
    write_modulus('0);
    send_request(OP_INSERT, 24'h313233, 32'hCAFE_0001);
    send_request(OP_INSERT, 24'h343536, 32'hCAFE_0002);
    send_request(OP_SEARCH, 24'h343536, 32'h0);
    send_request(OP_DELETE, 24'h313233, 32'h0);
    send_request(OP_SEARCH, 24'h313233, 32'h0);
    send_request(OP_INSERT, 24'h343536, 32'hCAFE_0003);
    drain();
    write_modulus(CNT_W'(1));
    send_request(OP_SEARCH, 24'h343536, 32'h0);
    drain();
    // Anything above the table depth is clipped to it.
    write_modulus('1);
    insert_new(24'h616263, 32'h0BAD_F00D);
    send_request(OP_SEARCH, 24'h616263, 32'h0);
    drain();
    write_modulus(DEPTH_CNT);
    send_request(OP_SEARCH, 24'h616263, 32'h0);
    insert_new(24'h646566, 32'h600D_F00D);
    drain();
  endtask

  // Entries stored under a small modulus stay put when the modulus grows.
  task automatic test_modulus_change;
    logic [KEY_W-1:0] keys[5];
    write_modulus(CNT_W'(7));
    for (int i = 0; i < 5; i++) begin
      keys[i] = KEY_W'($urandom);
      insert_new(keys[i], $urandom);
    end
    drain();
    write_modulus(MODULUS_RESET);
    for (int i = 0; i < 5; i++) send_request(OP_SEARCH, keys[i], 32'h0);
    drain();
  endtask

  // Mostly well-formed traffic on known keys, with some misses and no-ops.
  task automatic test_random_traffic(input logic [CNT_W-1:0] modulus, input int count);
    int pick;
    logic [KEY_W-1:0] key;
    write_modulus(modulus);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      key = (stored_keys.size() != 0)
          ? stored_keys[$urandom_range(stored_keys.size() - 1)] : KEY_W'($urandom);
      if (pick < 40 || stored_keys.size() == 0) begin
        insert_new(KEY_W'($urandom), $urandom);
      end else if (pick < 50) begin
        send_request(OP_INSERT, key, $urandom);
      end else if (pick < 70) begin
        send_request(OP_SEARCH, key, $urandom);
      end else if (pick < 88) begin
        send_request(OP_DELETE, key, $urandom);
      end else if (pick < 96) begin
        send_request(($urandom_range(1) != 0) ? OP_SEARCH : OP_DELETE,
                     KEY_W'($urandom), $urandom);
      end else begin
        send_request(OP_NONE, KEY_W'($urandom), $urandom);
      end
    end
    drain();
  endtask

  // The receiver holds off while requests keep coming, so the core backs up.
  task automatic test_backpressure;
    hold_ask = 1'b1;
    for (int i = 0; i < 10; i++) insert_new(KEY_W'($urandom), $urandom);
    for (int i = 0; i < 5; i++)
      send_request(OP_SEARCH, stored_keys[$urandom_range(stored_keys.size() - 1)], 32'h0);
    drain();
  endtask

  initial begin
    rst            = 1'b1;
    cfg_wen        = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    kind           = OP_NONE;
    key_code       = '0;
    entry_value    = '0;
    out_stall      = 1'b0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_ask       = 1'b0;
    quiet_cycles   = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_basic_ops();
    test_modulus_extremes();
    test_modulus_change();
    test_random_traffic(MODULUS_RESET, RANDOM_PER_PHASE);
    send_idle_pct = 61;
    test_random_traffic(DEPTH_CNT, RANDOM_PER_PHASE);
    send_idle_pct = 0;
    recv_stall_pct = 61;
    test_random_traffic(CNT_W'(509), RANDOM_PER_PHASE);
    send_idle_pct = 27;
    recv_stall_pct = 27;
    test_random_traffic('1, RANDOM_PER_PHASE);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
